### design/fbpw_pkg.sv
// Shared types and constants of the framebuffer pixel writer.
// Depends on nothing; every other design file imports it.
package fbpw_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_BASE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_PITCH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_MODE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLED       = 3'd5;

   // Field widths.
   localparam int ADDR_W  = 32;
   localparam int WADDR_W = 30;
   localparam int DATA_W  = 32;
   localparam int BE_W    = 4;
   localparam int POS_W   = 16;
   localparam int PITCH_W = 16;
   localparam int DIM_W   = 13;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_MAX_DIM     = 4096;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_32BPP = 2'd0,
      MODE_24BPP = 2'd1,
      MODE_16BPP = 2'd2,
      MODE_NONE  = 2'd3
   } fbpw_mode_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  frame_base;
      logic [PITCH_W-1:0] line_pitch;
      logic [DIM_W-1:0]   screen_width;
      logic [DIM_W-1:0]   screen_height;
      fbpw_mode_type      pixel_mode;
      logic               enabled;
   } fbpw_cfg_type;

   // One accepted pixel as it travels from the front to the back end.
   typedef struct packed {
      logic [ADDR_W-1:0] byte_addr;
      logic [DATA_W-1:0] value;
      fbpw_mode_type     mode;
   } fbpw_entry_type;

endpackage

### design/fbpw_front.sv
// Front end: accepts pixel words, clips them and forms byte address and packed color.
// Depends on fbpw_pkg.
module fbpw_front #(
   parameter int MAX_DIM = fbpw_pkg::DEFAULT_MAX_DIM
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fbpw_pkg::fbpw_cfg_type                cfg,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fbpw_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [fbpw_pkg::POS_W-1:0]     req_pos_y,
   input  logic [fbpw_pkg::DATA_W-1:0]           req_pixel_color,
   input  logic                                  queue_full,
   output logic                                  queue_push,
   output fbpw_pkg::fbpw_entry_type              queue_entry
);
   import fbpw_pkg::*;

   localparam int LIM_W  = $clog2(MAX_DIM + 1);
   localparam int CMP_W  = (LIM_W > POS_W ? LIM_W : POS_W) + 1;
   localparam int PROD_W = (POS_W - 1) + PITCH_W;
   localparam int XOFF_W = (POS_W - 1) + 2;
   localparam logic [CMP_W-1:0] MAX_DIM_EXT = CMP_W'(MAX_DIM);

   logic [CMP_W-1:0]  width_lim, height_lim, x_ext, y_ext;
   logic              keep, accept;
   logic [POS_W-2:0]  x_mag, y_mag;

   logic              a_valid_ff, a_valid_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [XOFF_W-1:0] xoff_ff, xoff_in;
   logic [DATA_W-1:0] value_ff, value_in;

   always_comb begin
      x_mag = req_pos_x[POS_W-2:0];
      y_mag = req_pos_y[POS_W-2:0];
      x_ext = CMP_W'(x_mag);
      y_ext = CMP_W'(y_mag);
      width_lim  = (CMP_W'(cfg.screen_width) > MAX_DIM_EXT) ? MAX_DIM_EXT
                                                           : CMP_W'(cfg.screen_width);
      height_lim = (CMP_W'(cfg.screen_height) > MAX_DIM_EXT) ? MAX_DIM_EXT
                                                            : CMP_W'(cfg.screen_height);
      keep = cfg.enabled && (cfg.frame_base != '0) && (cfg.line_pitch != '0) &&
             (width_lim != '0) && (height_lim != '0) && (cfg.pixel_mode != MODE_NONE) &&
             !req_pos_x[POS_W-1] && !req_pos_y[POS_W-1] &&
             (x_ext < width_lim) && (y_ext < height_lim);

      prod_in = PROD_W'(y_mag) * PROD_W'(cfg.line_pitch);
      case (cfg.pixel_mode)
         MODE_32BPP: begin
            xoff_in  = {x_mag, 2'b00};
            value_in = req_pixel_color;
         end
         MODE_24BPP: begin
            xoff_in  = XOFF_W'({x_mag, 1'b0}) + XOFF_W'(x_mag);
            value_in = {8'h00, req_pixel_color[23:0]};
         end
         MODE_16BPP: begin
            xoff_in  = XOFF_W'({x_mag, 1'b0});
            value_in = {16'h0000, req_pixel_color[23:19], req_pixel_color[15:10],
                        req_pixel_color[7:3]};
         end
         default: begin
            xoff_in  = '0;
            value_in = '0;
         end
      endcase

      // The stage holds its pixel only while the queue cannot take it.
      req_stall  = a_valid_ff && queue_full;
      accept     = req_valid && !req_stall;
      queue_push = a_valid_ff && !queue_full;
      if (accept) begin
         a_valid_in = keep;
      end else if (queue_push) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end

      queue_entry.byte_addr = cfg.frame_base + ADDR_W'(prod_ff) + ADDR_W'(xoff_ff);
      queue_entry.value     = value_ff;
      queue_entry.mode      = cfg.pixel_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff  <= prod_in;
         xoff_ff  <= xoff_in;
         value_ff <= value_in;
      end
   end

endmodule

### design/fbpw_queue.sv
// Short register queue that decouples the front end from the back end.
// Depends on fbpw_pkg.
module fbpw_queue #(
   parameter int DEPTH = fbpw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fbpw_pkg::fbpw_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output fbpw_pkg::fbpw_entry_type head_entry,
   output logic                     empty
);
   import fbpw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   fbpw_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      full       = (count_ff == FULL_CNT);
      empty      = (count_ff == '0);
      head_entry = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in  = pop ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/fbpw_back.sv
// Back end: places a pixel on byte lanes and issues one or two aligned word writes.
// Depends on fbpw_pkg.
module fbpw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  fbpw_pkg::fbpw_entry_type         head_entry,
   input  logic                             queue_empty,
   output logic                             queue_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fbpw_pkg::WADDR_W-1:0]     rsp_word_address,
   output logic [fbpw_pkg::DATA_W-1:0]      rsp_write_data,
   output logic [fbpw_pkg::BE_W-1:0]        rsp_byte_enable,
   output logic                             rsp_last_write
);
   import fbpw_pkg::*;

   logic [BE_W-1:0]     pix_mask;
   logic [2*BE_W-1:0]   lane_mask;
   logic [2*DATA_W-1:0] lanes;
   logic [1:0]          offs;
   logic                crossing, load;

   logic                out_valid_ff, out_valid_in;
   logic [WADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [DATA_W-1:0]   out_data_ff, out_data_in;
   logic [BE_W-1:0]     out_be_ff, out_be_in;
   logic                out_last_ff, out_last_in;

   logic                pend_valid_ff, pend_valid_in;
   logic [WADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [DATA_W-1:0]   pend_data_ff, pend_data_in;
   logic [BE_W-1:0]     pend_be_ff, pend_be_in;

   always_comb begin
      case (head_entry.mode)
         MODE_32BPP: pix_mask = 4'b1111;
         MODE_24BPP: pix_mask = 4'b0111;
         MODE_16BPP: pix_mask = 4'b0011;
         default:    pix_mask = 4'b0000;
      endcase
      offs      = head_entry.byte_addr[1:0];
      lane_mask = {4'b0000, pix_mask} << offs;
      lanes     = {{DATA_W{1'b0}}, head_entry.value} << {offs, 3'b000};
      crossing  = (lane_mask[2*BE_W-1:BE_W] != '0);

      // The output register reloads whenever it is empty or its word is taken.
      load      = !out_valid_ff || !rsp_stall;
      queue_pop = load && !pend_valid_ff && !queue_empty;

      out_valid_in  = out_valid_ff;
      out_addr_in   = out_addr_ff;
      out_data_in   = out_data_ff;
      out_be_in     = out_be_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      pend_be_in    = pend_be_ff;

      if (load) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_addr_in   = pend_addr_ff;
            out_data_in   = pend_data_ff;
            out_be_in     = pend_be_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!queue_empty) begin
            out_valid_in  = 1'b1;
            out_addr_in   = head_entry.byte_addr[ADDR_W-1:2];
            out_data_in   = lanes[DATA_W-1:0];
            out_be_in     = lane_mask[BE_W-1:0];
            out_last_in   = !crossing;
            pend_valid_in = crossing;
            pend_addr_in  = head_entry.byte_addr[ADDR_W-1:2] + 1'b1;
            pend_data_in  = lanes[2*DATA_W-1:DATA_W];
            pend_be_in    = lane_mask[2*BE_W-1:BE_W];
         end else begin
            out_valid_in  = 1'b0;
         end
      end

      rsp_valid        = out_valid_ff;
      rsp_word_address = out_addr_ff;
      rsp_write_data   = out_data_ff;
      rsp_byte_enable  = out_be_ff;
      rsp_last_write   = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff  <= out_addr_in;
      out_data_ff  <= out_data_in;
      out_be_ff    <= out_be_in;
      out_last_ff  <= out_last_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      pend_be_ff   <= pend_be_in;
   end

endmodule

### design/framebuffer_pixel_writer.sv
// Path: a kept pixel passes the front stage register, the queue and the back end's output
// register before its first word shows on rsp_. Throughput: one pixel per cycle while req_stall
// is low; a pixel that straddles a word boundary loads the back end's single output register twice.
// Clipped pixels are consumed and produce no word.
// Reset (synchronous, active high) empties every stage and the queue and loads the
// registers with zero, except pixel_mode, which comes up as unsupported.
// Depends on fbpw_pkg, fbpw_front, fbpw_queue and fbpw_back.
module framebuffer_pixel_writer #(
   parameter int MAX_DIM     = fbpw_pkg::DEFAULT_MAX_DIM,
   parameter int QUEUE_DEPTH = fbpw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write port.
   input  logic                                  csr_write,
   input  logic [fbpw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fbpw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // Pixel request channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fbpw_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [fbpw_pkg::POS_W-1:0]     req_pos_y,
   input  logic [fbpw_pkg::DATA_W-1:0]           req_pixel_color,
   // Memory write channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fbpw_pkg::WADDR_W-1:0]          rsp_word_address,
   output logic [fbpw_pkg::DATA_W-1:0]           rsp_write_data,
   output logic [fbpw_pkg::BE_W-1:0]             rsp_byte_enable,
   output logic                                  rsp_last_write
);
   import fbpw_pkg::*;

   // The configuration registers. The user changes them only while the block is idle,
   // which the block does not enforce. The front end reads them; entries copy only the mode.
   fbpw_cfg_type   cfg_ff, cfg_in;

   fbpw_entry_type push_entry, head_entry;
   logic           queue_push, queue_full, queue_pop, queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_BASE:    cfg_in.frame_base    = csr_wdata;
            REG_LINE_PITCH:    cfg_in.line_pitch    = csr_wdata[PITCH_W-1:0];
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[DIM_W-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[DIM_W-1:0];
            REG_PIXEL_MODE:    cfg_in.pixel_mode    = fbpw_mode_type'(csr_wdata[1:0]);
            REG_ENABLED:       cfg_in.enabled       = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base    <= '0;
         cfg_ff.line_pitch    <= '0;
         cfg_ff.screen_width  <= '0;
         cfg_ff.screen_height <= '0;
         cfg_ff.pixel_mode    <= MODE_NONE;
         cfg_ff.enabled       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end clips the pixel, multiplies row by pitch and packs the color ahead of
   // its stage register, and adds the address terms as the word enters the queue.
   fbpw_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pixel_color (req_pixel_color),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_entry     (push_entry)
   );

   // The queue lets the front keep taking pixels while the memory side stalls
   // or while the back end emits the second word of a straddling pixel.
   fbpw_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   // The back end shifts the pixel onto the byte lanes and emits the lower word,
   // then, for a straddling pixel, the following word with rsp_last_write set.
   fbpw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .queue_empty      (queue_empty),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_address (rsp_word_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_enable  (rsp_byte_enable),
      .rsp_last_write   (rsp_last_write)
   );

endmodule

### design/fbpw_checker.sv
// Port-level checks of the framebuffer pixel writer, attached by bind.
// Depends on fbpw_pkg and framebuffer_pixel_writer.
module fbpw_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [fbpw_pkg::WADDR_W-1:0]          rsp_word_address,
   input logic [fbpw_pkg::DATA_W-1:0]           rsp_write_data,
   input logic [fbpw_pkg::BE_W-1:0]             rsp_byte_enable,
   input logic                                  rsp_last_write
);
   import fbpw_pkg::*;

   // A word that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("write word dropped while stalled");

   // A held-back word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_word_address) && $stable(rsp_write_data) &&
                                 $stable(rsp_byte_enable) && $stable(rsp_last_write))
      else $error("write word changed while stalled");

   // A first word of a straddling pixel reaches the top byte lane.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_write |-> rsp_byte_enable[BE_W-1])
      else $error("non-final word does not reach the word boundary");

   // The second word of a straddling pixel follows at once, at the next address,
   // starting from the lowest byte lane.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_write |=>
         rsp_valid && rsp_last_write && rsp_byte_enable[0] &&
         (rsp_word_address == $past(rsp_word_address) + 1'b1))
      else $error("second word of a straddling pixel missing or misplaced");

endmodule

bind framebuffer_pixel_writer fbpw_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_word_address (rsp_word_address),
   .rsp_write_data   (rsp_write_data),
   .rsp_byte_enable  (rsp_byte_enable),
   .rsp_last_write   (rsp_last_write)
);

### dv/fbpw_write_checker.sv
// Checker for the framebuffer pixel writer: it tracks the register writes, predicts the
// word writes of every accepted pixel and compares them with the block's memory writes.
// Depends on fbpw_pkg.
module fbpw_write_checker
   import fbpw_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [POS_W-1:0]          req_pos_x,
   input  logic [POS_W-1:0]          req_pos_y,
   input  logic [DATA_W-1:0]         req_pixel_color,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [WADDR_W-1:0]        rsp_word_address,
   input  logic [DATA_W-1:0]         rsp_write_data,
   input  logic [BE_W-1:0]           rsp_byte_enable,
   input  logic                      rsp_last_write,
   input  logic                      run_over,
   output int                        fail_count,
   output int                        writes_pending,
   output int                        writes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 20;

   typedef struct packed {
      logic [WADDR_W-1:0] word_address;
      logic [DATA_W-1:0]  write_data;
      logic [BE_W-1:0]    byte_enable;
      logic               last_write;
   } word_write_type;

   // Our own copy of the register file.
   logic [ADDR_W-1:0]  base_q;
   logic [PITCH_W-1:0] pitch_q;
   logic [DIM_W-1:0]   width_q;
   logic [DIM_W-1:0]   height_q;
   fbpw_mode_type      mode_q;
   logic               enabled_q;

   word_write_type expected_writes[$];
   logic           leftovers_done;

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) $display("checker: %s", what);
   endtask

   // Works out the word writes, none, one or two, that a pixel request causes.
   task automatic predict_word_writes(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                      input logic [DATA_W-1:0] color);
      int unsigned    w;
      int unsigned    h;
      int unsigned    nbytes;
      logic [31:0]    value;
      logic [31:0]    addr;
      logic [1:0]     offs;
      logic [7:0]     mask;
      logic [63:0]    lanes;
      word_write_type wr;
      w = (width_q > MAX_DIM) ? MAX_DIM : width_q;
      h = (height_q > MAX_DIM) ? MAX_DIM : height_q;
      if (!enabled_q || base_q == 0 || pitch_q == 0 || w == 0 || h == 0) return;
      if (mode_q == MODE_NONE) return;
      if (x[POS_W-1] || y[POS_W-1]) return;
      if (x >= w || y >= h) return;
      case (mode_q)
         MODE_32BPP: begin
            nbytes = 4;
            value = color;
         end
         MODE_24BPP: begin
            nbytes = 3;
            value = {8'h00, color[23:0]};
         end
         default: begin
            // RGB565 keeps the top five, six and five bits of red, green and blue.
            nbytes = 2;
            value = {16'h0000, color[23:19], color[15:10], color[7:3]};
         end
      endcase
      addr = base_q + 32'(y) * 32'(pitch_q) + 32'(x) * nbytes;
      offs = addr[1:0];
      mask = 8'(((32'd1 << nbytes) - 32'd1) << offs);
      lanes = 64'(value) << (8 * offs);
      wr.word_address = addr[31:2];
      wr.write_data   = lanes[31:0];
      wr.byte_enable  = mask[3:0];
      wr.last_write   = (offs + nbytes <= 4);
      expected_writes.push_back(wr);
      if (offs + nbytes > 4) begin
         // The upper part spills into the next word, which wraps at the top of memory.
         wr.word_address = addr[31:2] + 30'd1;
         wr.write_data   = lanes[63:32];
         wr.byte_enable  = mask[7:4];
         wr.last_write   = 1'b1;
         expected_writes.push_back(wr);
      end
   endtask

   always @(posedge clock) begin
      word_write_type want;
      if (reset) begin
         base_q         <= '0;
         pitch_q        <= '0;
         width_q        <= '0;
         height_q       <= '0;
         mode_q         <= MODE_NONE;
         enabled_q      <= 1'b0;
         expected_writes.delete();
         leftovers_done <= 1'b0;
         fail_count     = 0;
         writes_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            writes_checked++;
            if (expected_writes.size() == 0) begin
               report_mismatch($sformatf("write to word %h with nothing expected",
                                         rsp_word_address));
            end else begin
               want = expected_writes.pop_front();
               if (rsp_word_address !== want.word_address)
                  report_mismatch($sformatf("write %0d: word_address %h, expected %h",
                                            writes_checked, rsp_word_address,
                                            want.word_address));
               if (rsp_write_data !== want.write_data)
                  report_mismatch($sformatf("write %0d: write_data %h, expected %h",
                                            writes_checked, rsp_write_data,
                                            want.write_data));
               if (rsp_byte_enable !== want.byte_enable)
                  report_mismatch($sformatf("write %0d: byte_enable %b, expected %b",
                                            writes_checked, rsp_byte_enable,
                                            want.byte_enable));
               if (rsp_last_write !== want.last_write)
                  report_mismatch($sformatf("write %0d: last_write %b, expected %b",
                                            writes_checked, rsp_last_write,
                                            want.last_write));
            end
         end
         if (req_valid && !req_stall)
            predict_word_writes(req_pos_x, req_pos_y, req_pixel_color);
         // Register writes only happen while the block is idle, so ordering them after
         // the prediction above changes nothing.
         if (csr_write) begin
            case (csr_index)
               REG_FRAME_BASE:    base_q    <= csr_wdata[ADDR_W-1:0];
               REG_LINE_PITCH:    pitch_q   <= csr_wdata[PITCH_W-1:0];
               REG_SCREEN_WIDTH:  width_q   <= csr_wdata[DIM_W-1:0];
               REG_SCREEN_HEIGHT: height_q  <= csr_wdata[DIM_W-1:0];
               REG_PIXEL_MODE:    mode_q    <= fbpw_mode_type'(csr_wdata[1:0]);
               REG_ENABLED:       enabled_q <= csr_wdata[0];
               default: ;
            endcase
         end
         if (run_over && !leftovers_done) begin
            leftovers_done <= 1'b1;
            if (expected_writes.size() != 0)
               report_mismatch($sformatf("%0d writes never arrived, first to word %h",
                                         expected_writes.size(),
                                         expected_writes[0].word_address));
         end
      end
      writes_pending = expected_writes.size();
   end

endmodule

### dv/testbench.sv
// Top of the framebuffer pixel writer testbench: clock, reset, register set-up and pixel
// stimulus, write-side stalls, a watchdog and the verdict.
// Depends on fbpw_pkg, framebuffer_pixel_writer and fbpw_write_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fbpw_pkg::*;

   // Indexes that decode to no register; writes to them must have no effect.
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP   = 3'd7;

   localparam int LONG_HOLD     = 200;   // cycles of the long write-side hold
   localparam int QUIET_LIMIT   = 1000;  // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES  = 8;     // covers the front stage, the queue and the outputs
   localparam int SEGMENTS      = 5;     // random register settings per idling phase
   localparam int SEGMENT_ITEMS = 85;
   localparam int HOLD_ITEMS    = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [POS_W-1:0]   req_pos_x = '0;
   logic signed [POS_W-1:0]   req_pos_y = '0;
   logic [DATA_W-1:0]         req_pixel_color = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [WADDR_W-1:0]        rsp_word_address;
   logic [DATA_W-1:0]         rsp_write_data;
   logic [BE_W-1:0]           rsp_byte_enable;
   logic                      rsp_last_write;

   int   src_idle_pct = 0;
   int   sink_stall_pct = 0;
   int   hold_left = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   eff_width = 0;
   int   eff_height = 0;
   int   pixels_sent = 0;
   int   settings_used = 0;
   int   quiet_cycles = 0;
   logic run_over = 1'b0;
   int   fail_count;
   int   writes_pending;
   int   writes_checked;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   framebuffer_pixel_writer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_address (rsp_word_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_enable  (rsp_byte_enable),
      .rsp_last_write   (rsp_last_write)
   );

   fbpw_write_checker u_write_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_address (rsp_word_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_enable  (rsp_byte_enable),
      .rsp_last_write   (rsp_last_write),
      .run_over         (run_over),
      .fail_count       (fail_count),
      .writes_pending   (writes_pending),
      .writes_checked   (writes_checked)
   );

   // The memory side. It normally stalls at the phase's rate, but when the stimulus
   // flips hold_toggle it holds stall high for a long stretch so that the block's queue
   // fills up and the pixel side is pushed back.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = LONG_HOLD - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < sink_stall_pct);
      end
   end

   // Watchdog: any word moved on either channel, or any register write, counts as
   // progress. A long quiet stretch means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Offers one pixel word and returns at the falling edge after it was taken.
   // Valid stays high afterwards, so back-to-back pixels need no gap.
   task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [DATA_W-1:0] color);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_pos_x       = x;
      req_pos_y       = y;
      req_pixel_color = color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
   endtask

   // Stops offering pixels and waits until every predicted write has come out. Clipped
   // pixels leave no trace in the prediction, so a DRAIN_CYCLES wait lets them retire too.
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (writes_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
   endtask

   // Loads all six registers while the block is idle. The values may carry junk above
   // each register's width, which the block must drop.
   task automatic set_registers(input logic [31:0] base, input logic [31:0] pitch,
                                input logic [31:0] width, input logic [31:0] height,
                                input logic [31:0] mode, input logic [31:0] enable);
      wait_for_drain();
      if ($urandom_range(3) == 0)
         write_register($urandom_range(1) ? CSR_INDEX_SPARE : CSR_INDEX_TOP, $urandom());
      write_register(REG_FRAME_BASE, base);
      write_register(REG_LINE_PITCH, pitch);
      write_register(REG_SCREEN_WIDTH, width);
      write_register(REG_SCREEN_HEIGHT, height);
      write_register(REG_PIXEL_MODE, mode);
      write_register(REG_ENABLED, enable);
      csr_write = 1'b0;
      // The visible area, used only to aim the random pixels.
      eff_width  = (width[DIM_W-1:0] > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : width[DIM_W-1:0];
      eff_height = (height[DIM_W-1:0] > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM
                                                         : height[DIM_W-1:0];
      settings_used++;
   endtask

   // Picks a random setting. Most are usable; a few break one condition so that the
   // block must drop everything, and some sit at the extremes of each register.
   task automatic random_setup();
      logic [31:0] base;
      logic [31:0] pitch;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] mode;
      logic [31:0] enable;
      base = $urandom();
      case ($urandom_range(3))
         0: base = 32'hFFFF_FF00 | $urandom_range(255);
         1: base = 32'hFFFF_FFFF;
         2: base = $urandom_range(1, 4095);
         default: ;
      endcase
      pitch = ($urandom() & 32'hFFFF_0000) |
              ($urandom_range(3) == 0 ? 32'h0000_FFFF : $urandom_range(1, 65535));
      case ($urandom_range(7))
         0: width = $urandom_range(1, 16);
         1: width = DEFAULT_MAX_DIM;
         2: width = $urandom_range(DEFAULT_MAX_DIM + 1, 8191);
         default: width = $urandom_range(1, 2048);
      endcase
      case ($urandom_range(7))
         0: height = $urandom_range(1, 16);
         1: height = DEFAULT_MAX_DIM;
         2: height = $urandom_range(DEFAULT_MAX_DIM + 1, 8191);
         default: height = $urandom_range(1, 2048);
      endcase
      width  = width | ($urandom() & 32'hFFFF_E000);
      height = height | ($urandom() & 32'hFFFF_E000);
      mode   = ($urandom() & 32'hFFFF_FFFC) | $urandom_range(MODE_32BPP, MODE_16BPP);
      enable = $urandom() | 32'd1;
      case ($urandom_range(31))
         0: base = '0;
         1: pitch = pitch & 32'hFFFF_0000;
         2: width = width & 32'hFFFF_E000;
         3: height = height & 32'hFFFF_E000;
         4: mode[1:0] = MODE_NONE;
         5: enable[0] = 1'b0;
         default: ;
      endcase
      set_registers(base, pitch, width, height, mode, enable);
   endtask

   // Mostly pixels on the screen, some right at its right and bottom edges, and some
   // with any 16-bit coordinates at all, negative ones included.
   task automatic random_pixel();
      int roll;
      int x;
      int y;
      roll = $urandom_range(99);
      if (roll < 80 && eff_width > 0 && eff_height > 0) begin
         x = $urandom_range(eff_width - 1);
         y = $urandom_range(eff_height - 1);
      end else if (roll < 90) begin
         x = eff_width - 1 + $urandom_range(2);
         y = $urandom_range(1) ? eff_height - 1 + $urandom_range(2) : 0;
      end else begin
         x = $urandom();
         y = $urandom();
      end
      send_pixel(16'(x), 16'(y), $urandom());
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed part. 32 bits per pixel: screen corners, just off each edge, negative
      // and extreme coordinates, all-ones and all-zero colors.
      set_registers(32'h0000_1000, 2560, 640, 480, MODE_32BPP, 1);
      send_pixel(0, 0, 32'h0000_0000);
      send_pixel(639, 479, 32'hFFFF_FFFF);
      send_pixel(640, 0, 32'h0012_3456);
      send_pixel(0, 480, 32'h0065_4321);
      send_pixel(-1, 5, 32'h00FF_FFFF);
      send_pixel(5, -1, 32'h00FF_FFFF);
      send_pixel(-32768, 32767, 32'h8000_0001);
      send_pixel(32767, -32768, 32'h7FFF_FFFE);
      // 24 bits per pixel on an odd base: fits in a word, and crosses at two offsets.
      set_registers(32'h1000_0001, 1920, 640, 480, MODE_24BPP, 1);
      send_pixel(0, 0, 32'hA5C3_5A3C);
      send_pixel(1, 0, 32'h5A3C_A5C3);
      send_pixel(2, 0, 32'hFFFF_FFFF);
      send_pixel(3, 0, 32'h0080_8080);
      // RGB565 with a pixel straddling a word at the last byte lane.
      set_registers(32'h2000_0003, 1280, 640, 480, MODE_16BPP, 1);
      send_pixel(0, 0, 32'h00F8_FCF8);
      send_pixel(1, 0, 32'h0007_0307);
      send_pixel(0, 1, 32'hFFFF_FFFF);
      // Oversized screen clamps to the largest size; the base near the top of memory
      // makes the address wrap, the second word going from the last word to word zero.
      set_registers(32'hFFFF_FFFE, 4, 8191, 8191, MODE_32BPP, 1);
      send_pixel(0, 0, 32'hDEAD_BEEF);
      send_pixel(4095, 0, 32'h0102_0304);
      send_pixel(4096, 0, 32'h0506_0708);
      send_pixel(0, 4095, 32'h090A_0B0C);
      // Five reasons for dropping a pixel. The pitch and width values only have
      // bits above the register width, so they land as zero.
      set_registers(32'h0000_1000, 64, 16, 16, MODE_32BPP, 0);
      send_pixel(1, 1, 32'h0011_2233);
      set_registers(32'h0000_0000, 64, 16, 16, MODE_32BPP, 1);
      send_pixel(1, 1, 32'h0011_2233);
      set_registers(32'h0000_1000, 64, 16, 16, MODE_NONE, 1);
      send_pixel(1, 1, 32'h0011_2233);
      set_registers(32'h0000_1000, 32'h0001_0000, 16, 16, MODE_32BPP, 1);
      send_pixel(1, 1, 32'h0011_2233);
      set_registers(32'h0000_1000, 64, 32'h0000_2000, 16, MODE_32BPP, 1);
      send_pixel(1, 1, 32'h0011_2233);

      // Random part, in four idling phases: none, pixel side idle about half the time,
      // memory side stalling about half the time, and both at about a fifth.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
            default: begin src_idle_pct = 21; sink_stall_pct = 21; end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            random_setup();
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
               random_pixel();
               // Once per phase the pixel side pauses until every write is out.
               if (seg == 2 && n == SEGMENT_ITEMS / 2) wait_for_drain();
            end
         end
         if (phase == 0) begin
            // Long memory-side hold while pixels keep coming: 24-bit pixels, many of
            // them straddling words, so the block fills up and stalls its input.
            set_registers(32'h0000_1003, 3000, 1000, 600, MODE_24BPP, 1);
            hold_toggle <= ~hold_toggle;
            repeat (HOLD_ITEMS) random_pixel();
         end
      end

      wait_for_drain();
      run_over = 1'b1;
      repeat (2) @(negedge clock);
      $display("testbench: %0d pixels over %0d register settings, %0d word writes compared",
               pixels_sent, settings_used, writes_checked);
      $display("testbench: all pixel modes, clipping, wraparound and a long memory hold ran");
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
